// ===== hw/rtl/plsbe_pkg.sv =====
// ----------------------------------------------------------------------------
// plsbe_pkg - shared types and constants for the parallel LED strip encoder
// Widths, register map, reset values and the item types passed between the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
package plsbe_pkg;

  // Strip count and frame store depth
  localparam int STRIPS    = 5;
  localparam int MAX_BYTES = 1024;
  localparam int ADDR_W    = $clog2(MAX_BYTES);

  // Payload field widths
  localparam int SEL_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 16;
  localparam int RP_W     = 8;
  localparam int FB_W     = 11;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register map (word index)
  typedef enum logic [2:0] {
    REG_PERIOD    = 3'd0,
    REG_HIGH_ZERO = 3'd1,
    REG_HIGH_ONE  = 3'd2,
    REG_RESET_PER = 3'd3,
    REG_FRAME_LEN = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [TICK_W-1:0] PERIOD_RST    = TICK_W'(90);
  localparam logic [TICK_W-1:0] HIGH_ZERO_RST = TICK_W'(28);
  localparam logic [TICK_W-1:0] HIGH_ONE_RST  = TICK_W'(57);
  localparam logic [RP_W-1:0]   RESET_PER_RST = RP_W'(50);
  localparam logic [FB_W-1:0]   FRAME_LEN_RST = FB_W'(768);

  // Live configuration
  typedef struct packed {
    logic [TICK_W-1:0] period_ticks;
    logic [TICK_W-1:0] high_zero_ticks;
    logic [TICK_W-1:0] high_one_ticks;
    logic [RP_W-1:0]   reset_periods;
    logic [FB_W-1:0]   frame_bytes;
  } cfg_t;

  // Classified item from the front end
  typedef struct packed {
    logic              is_write;
    logic              wr_en;
    logic [SEL_W-1:0]  sel;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] val;
  } op_t;

  // One frame store row: one byte per strip
  typedef logic [STRIPS-1:0][BYTE_W-1:0] row_t;

endpackage

// ===== hw/rtl/plsbe_if.sv =====
// ----------------------------------------------------------------------------
// plsbe_if - item and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface plsbe_item_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [plsbe_pkg::SEL_W-1:0]   strip_sel;
  logic [plsbe_pkg::ADDR_W-1:0]  byte_addr;
  logic [plsbe_pkg::BYTE_W-1:0]  byte_value;

  modport source (output valid, cmd, strip_sel, byte_addr, byte_value, input ready);
  modport sink   (input valid, cmd, strip_sel, byte_addr, byte_value, output ready);
endinterface

interface plsbe_result_if;
  logic                          valid;
  logic                          ready;
  logic [plsbe_pkg::STRIPS-1:0]  pin_levels;
  logic                          in_latch;

  modport source (output valid, pin_levels, in_latch, input ready);
  modport sink   (input valid, pin_levels, in_latch, output ready);
endinterface

// ===== hw/rtl/plsbe_cfg.sv =====
// ----------------------------------------------------------------------------
// plsbe_cfg - APB register block
// Holds the timing and frame length registers; write on the access phase.
// ----------------------------------------------------------------------------
module plsbe_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plsbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [plsbe_pkg::PDATA_W-1:0]  pwdata,
  output logic [plsbe_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output plsbe_pkg::cfg_t                cfg
);

  plsbe_pkg::reg_idx_t idx;
  logic                wr;

  assign idx    = plsbe_pkg::reg_idx_t'(paddr[plsbe_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks    <= plsbe_pkg::PERIOD_RST;
      cfg.high_zero_ticks <= plsbe_pkg::HIGH_ZERO_RST;
      cfg.high_one_ticks  <= plsbe_pkg::HIGH_ONE_RST;
      cfg.reset_periods   <= plsbe_pkg::RESET_PER_RST;
      cfg.frame_bytes     <= plsbe_pkg::FRAME_LEN_RST;
    end else if (wr) begin
      unique case (idx)
        plsbe_pkg::REG_PERIOD:    cfg.period_ticks    <= pwdata[plsbe_pkg::TICK_W-1:0];
        plsbe_pkg::REG_HIGH_ZERO: cfg.high_zero_ticks <= pwdata[plsbe_pkg::TICK_W-1:0];
        plsbe_pkg::REG_HIGH_ONE:  cfg.high_one_ticks  <= pwdata[plsbe_pkg::TICK_W-1:0];
        plsbe_pkg::REG_RESET_PER: cfg.reset_periods   <= pwdata[plsbe_pkg::RP_W-1:0];
        plsbe_pkg::REG_FRAME_LEN: cfg.frame_bytes     <= pwdata[plsbe_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      plsbe_pkg::REG_PERIOD:    prdata = plsbe_pkg::PDATA_W'(cfg.period_ticks);
      plsbe_pkg::REG_HIGH_ZERO: prdata = plsbe_pkg::PDATA_W'(cfg.high_zero_ticks);
      plsbe_pkg::REG_HIGH_ONE:  prdata = plsbe_pkg::PDATA_W'(cfg.high_one_ticks);
      plsbe_pkg::REG_RESET_PER: prdata = plsbe_pkg::PDATA_W'(cfg.reset_periods);
      plsbe_pkg::REG_FRAME_LEN: prdata = plsbe_pkg::PDATA_W'(cfg.frame_bytes);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/plsbe_front.sv =====
// ----------------------------------------------------------------------------
// plsbe_front - item intake
// Takes item beats, sorts ticks from writes, masks writes to absent strips.
// ----------------------------------------------------------------------------
module plsbe_front (
  input  logic           clk,
  input  logic           rst,
  plsbe_item_if.sink     item,
  input  logic           clearing,
  output plsbe_pkg::op_t op,
  output logic           op_valid,
  input  logic           op_ready
);

  logic fv;
  logic take;

  // Hold off while the frame store is swept after reset
  assign item.ready = !clearing && (!fv || op_ready);
  assign take       = item.valid && item.ready;
  assign op_valid   = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (op_ready) begin
      fv <= 1'b0;
    end
  end

  // Classify the beat
  always_ff @(posedge clk) begin
    if (take) begin
      op.is_write <= (item.cmd == plsbe_pkg::CMD_WRITE);
      op.wr_en    <= (item.cmd == plsbe_pkg::CMD_WRITE)
                     && (item.strip_sel < plsbe_pkg::SEL_W'(plsbe_pkg::STRIPS));
      op.sel      <= item.strip_sel;
      op.addr     <= item.byte_addr;
      op.val      <= item.byte_value;
    end
  end

endmodule

// ===== hw/rtl/plsbe_queue.sv =====
// ----------------------------------------------------------------------------
// plsbe_queue - two-entry item queue
// Decouples the intake from the waveform engine.
// ----------------------------------------------------------------------------
module plsbe_queue (
  input  logic           clk,
  input  logic           rst,
  input  plsbe_pkg::op_t in_op,
  input  logic           in_valid,
  output logic           in_ready,
  output plsbe_pkg::op_t out_op,
  output logic           out_valid,
  input  logic           out_ready
);

  plsbe_pkg::op_t ent [2];
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic           push;
  logic           pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_op    = ent[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= in_op;
  end

endmodule

// ===== hw/rtl/plsbe_back.sv =====
// ----------------------------------------------------------------------------
// plsbe_back - frame store and waveform engine
// Holds the frame store, tracks tick/bit/byte/latch position, prefetches the
// next row and produces one pin level result per item.
// ----------------------------------------------------------------------------
module plsbe_back (
  input  logic            clk,
  input  logic            rst,
  input  plsbe_pkg::op_t  op,
  input  logic            op_valid,
  output logic            op_ready,
  input  plsbe_pkg::cfg_t cfg,
  output logic            clearing,
  plsbe_result_if.source  result
);

  localparam int AW = plsbe_pkg::ADDR_W;
  localparam int FW = plsbe_pkg::FB_W;
  localparam int TW = plsbe_pkg::TICK_W;

  // Clear sweep
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // Frame store and prefetch
  plsbe_pkg::row_t mem [plsbe_pkg::MAX_BYTES];
  plsbe_pkg::row_t rd_row;
  plsbe_pkg::row_t nrow;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   ra_q;
  logic            wq_v;
  logic [AW-1:0]   wq_addr;
  logic [plsbe_pkg::SEL_W-1:0]  wq_sel;
  logic [plsbe_pkg::BYTE_W-1:0] wq_val;

  // Position state
  logic [TW-1:0]                tick_count, tick_count_next;
  logic [2:0]                   bit_pos, bit_pos_next;
  logic [AW-1:0]                byte_pos, byte_pos_next;
  logic [plsbe_pkg::RP_W-1:0]   latch_count, latch_count_next;
  logic                         latching, latching_next;
  plsbe_pkg::row_t              cur_row, cur_row_next;
  plsbe_pkg::row_t              row_eff;

  // Misc
  logic                         exec;
  logic                         do_wr;
  logic [FW-1:0]                fb_eff;
  logic [FW-1:0]                pos_inc;
  logic                         wrap;
  logic [TW:0]                  tick_sum;
  logic                         period_end;
  logic [plsbe_pkg::STRIPS-1:0] lv;
  logic                         ov;

  assign clearing = clr_busy;
  assign op_ready = !ov || result.ready;
  assign exec     = op_valid && op_ready;
  assign do_wr    = exec && op.wr_en;

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(plsbe_pkg::MAX_BYTES - 1)) clr_busy <= 1'b0;
    end
  end

  // Frame store: one byte-lane write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (do_wr) begin
      mem[op.addr][op.sel] <= op.val;
    end
    rd_row <= mem[ra];
  end

  // Next byte position to fetch
  always_comb begin
    if (cfg.frame_bytes == '0) begin
      fb_eff = FW'(1);
    end else if (cfg.frame_bytes > FW'(plsbe_pkg::MAX_BYTES)) begin
      fb_eff = FW'(plsbe_pkg::MAX_BYTES);
    end else begin
      fb_eff = cfg.frame_bytes;
    end
    pos_inc = FW'(byte_pos) + FW'(1);
    wrap    = (pos_inc >= fb_eff);
    ra      = (latching || wrap) ? '0 : pos_inc[AW-1:0];
  end

  // Track the last write so the prefetched row sees it
  always_ff @(posedge clk) begin
    ra_q    <= ra;
    wq_addr <= op.addr;
    wq_sel  <= op.sel;
    wq_val  <= op.val;
  end

  always_ff @(posedge clk) begin
    if (rst) wq_v <= 1'b0;
    else     wq_v <= do_wr;
  end

  always_comb begin
    nrow = rd_row;
    if (wq_v && (wq_addr == ra_q)) nrow[wq_sel] = wq_val;
  end

  // Current row with this cycle's write folded in
  always_comb begin
    row_eff = cur_row;
    if (do_wr && (op.addr == byte_pos)) row_eff[op.sel] = op.val;
  end

  // Pin levels for this tick
  always_comb begin
    for (int s = 0; s < plsbe_pkg::STRIPS; s++) begin
      lv[s] = !latching && (tick_count < (row_eff[s][~bit_pos] ? cfg.high_one_ticks
                                                                : cfg.high_zero_ticks));
    end
  end

  // Time advance
  assign tick_sum   = {1'b0, tick_count} + (TW+1)'(1);
  assign period_end = (tick_sum >= {1'b0, cfg.period_ticks});

  always_comb begin
    tick_count_next  = tick_count;
    bit_pos_next     = bit_pos;
    byte_pos_next    = byte_pos;
    latch_count_next = latch_count;
    latching_next    = latching;
    cur_row_next     = cur_row;
    if (exec) begin
      if (op.is_write) begin
        cur_row_next = row_eff;
      end else begin
        tick_count_next = period_end ? '0 : tick_sum[TW-1:0];
        if (period_end) begin
          if (latching) begin
            if (latch_count >= cfg.reset_periods) begin
              latch_count_next = '0;
              latching_next    = 1'b0;
              bit_pos_next     = '0;
              byte_pos_next    = '0;
              cur_row_next     = nrow;
            end else begin
              latch_count_next = latch_count + plsbe_pkg::RP_W'(1);
            end
          end else begin
            bit_pos_next = bit_pos + 3'd1;
            if (bit_pos == 3'd7) begin
              cur_row_next = nrow;
              if (wrap) begin
                byte_pos_next    = '0;
                latching_next    = 1'b1;
                latch_count_next = '0;
              end else begin
                byte_pos_next = pos_inc[AW-1:0];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      bit_pos     <= '0;
      byte_pos    <= '0;
      latch_count <= '0;
      latching    <= 1'b1;
      cur_row     <= '0;
    end else begin
      tick_count  <= tick_count_next;
      bit_pos     <= bit_pos_next;
      byte_pos    <= byte_pos_next;
      latch_count <= latch_count_next;
      latching    <= latching_next;
      cur_row     <= cur_row_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (exec) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result.pin_levels <= lv;
      result.in_latch   <= latching;
    end
  end

  assign result.valid = ov;

endmodule

// ===== hw/rtl/parallel_led_strip_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// parallel_led_strip_bit_encoder - multi-strip single-wire LED bit encoder
// Drives five LED strip pins in parallel from a byte frame store.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready beats. cmd=0 advances the waveform one tick, cmd=1
//            stores byte_value for strip strip_sel at byte_addr.
//   result : one beat per item with pin_levels (bit l = strip l) and in_latch.
//            A tick reports the levels during that tick; a write reports the
//            levels of the current tick with the new byte already applied.
//   APB    : five registers at byte offsets 0,4,8,12,16 (period, high time
//            for 0 and 1 bits, latch periods, frame length); write only idle.
// Timing: one item per clock sustained while results are taken; the
//   tick/bit/byte update in the back end is combinational and registered,
//   and the next frame row is prefetched from the store's registered read
//   port. An item passes the intake register, the queue and the result
//   register before its result beat.
// Reset: registers take their defaults, the engine starts in the latch
//   interval, and the 1024-row frame store is swept to zero with item.ready
//   held low; APB writes are taken during the sweep.
// Stall: when result is not taken the result register holds, the two-entry
//   queue and intake register fill, then item.ready drops.
// ----------------------------------------------------------------------------
module parallel_led_strip_bit_encoder (
  input  logic                           clk,
  input  logic                           rst,
  plsbe_item_if.sink                     item,
  plsbe_result_if.source                 result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plsbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [plsbe_pkg::PDATA_W-1:0]  pwdata,
  output logic [plsbe_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  plsbe_pkg::cfg_t cfg;
  plsbe_pkg::op_t  f_op;
  plsbe_pkg::op_t  q_op;
  logic            f_valid;
  logic            f_ready;
  logic            q_valid;
  logic            q_ready;
  logic            clearing;

  plsbe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plsbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .clearing (clearing),
    .op       (f_op),
    .op_valid (f_valid),
    .op_ready (f_ready)
  );

  plsbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_op     (f_op),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_op    (q_op),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  plsbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_op),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .cfg      (cfg),
    .clearing (clearing),
    .result   (result)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the parallel LED strip bit encoder
// Streams tick and frame-write beats into the encoder, mirrors the waveform
// engine (frame store, tick/bit/byte counters, latch interval) in a behavioural
// model, and compares every result beat, field by field, with its prediction.
// Timing registers are reprogrammed over APB between phases while idle.
// ----------------------------------------------------------------------------
module tb;

  // Cycles without any beat before the run is declared hung; covers the store
  // sweep after reset plus worst-case gaps and stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // Register index past the end of the map, must be ignored
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic                         hold;   // wait for every result before sending
    logic                         cmd;
    logic [plsbe_pkg::SEL_W-1:0]  sel;
    logic [plsbe_pkg::ADDR_W-1:0] addr;
    logic [plsbe_pkg::BYTE_W-1:0] val;
  } strip_cmd_t;

  typedef struct packed {
    logic [plsbe_pkg::STRIPS-1:0] pins;
    logic                         latch;
  } pin_view_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [plsbe_pkg::PADDR_W-1:0] paddr;
  logic [plsbe_pkg::PDATA_W-1:0] pwdata;
  logic [plsbe_pkg::PDATA_W-1:0] prdata;
  logic                          pready;

  plsbe_item_if   item_ch ();
  plsbe_result_if result_ch ();

  parallel_led_strip_bit_encoder uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to go out, and pin views still owed by the encoder
  strip_cmd_t cmd_backlog [$];
  pin_view_t  levels_due [$];

  logic item_taken   = 1'b0;
  logic result_taken = 1'b0;
  int   send_gap     = 0;
  int   take_gap     = 0;
  bit   send_quiet   = 1'b0;
  bit   take_quiet   = 1'b0;
  int   mismatches   = 0;
  int   idle_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Behavioural model of the waveform engine
  // ---------------------------------------------------------------------------
  bit   [plsbe_pkg::BYTE_W-1:0] frame_copy [plsbe_pkg::MAX_BYTES][plsbe_pkg::STRIPS];
  logic [plsbe_pkg::TICK_W-1:0] tick_now    = '0;
  logic [2:0]                   bit_now     = '0;
  logic [plsbe_pkg::FB_W-1:0]   byte_now    = '0;
  logic [plsbe_pkg::RP_W-1:0]   latch_done  = '0;
  logic                         latch_phase = 1'b1;

  logic [plsbe_pkg::TICK_W-1:0] cfg_period = plsbe_pkg::PERIOD_RST;
  logic [plsbe_pkg::TICK_W-1:0] cfg_high0  = plsbe_pkg::HIGH_ZERO_RST;
  logic [plsbe_pkg::TICK_W-1:0] cfg_high1  = plsbe_pkg::HIGH_ONE_RST;
  logic [plsbe_pkg::RP_W-1:0]   cfg_latch  = plsbe_pkg::RESET_PER_RST;
  logic [plsbe_pkg::FB_W-1:0]   cfg_frame  = plsbe_pkg::FRAME_LEN_RST;

  // Pin levels for the current tick; pins stay low through the latch
  function automatic logic [plsbe_pkg::STRIPS-1:0] live_pins();
    logic [plsbe_pkg::STRIPS-1:0] lv;
    logic [plsbe_pkg::TICK_W-1:0] high_for;
    lv = '0;
    if (!latch_phase) begin
      for (int s = 0; s < plsbe_pkg::STRIPS; s++) begin
        high_for = frame_copy[byte_now][s][3'd7 - bit_now] ? cfg_high1 : cfg_high0;
        lv[s] = tick_now < high_for;
      end
    end
    return lv;
  endfunction

  // Step bit, byte and latch counters at the end of a bit period
  function automatic void close_period();
    logic [plsbe_pkg::FB_W-1:0] frame_len;
    if (cfg_frame == '0)
      frame_len = plsbe_pkg::FB_W'(1);
    else if (cfg_frame > plsbe_pkg::FB_W'(plsbe_pkg::MAX_BYTES))
      frame_len = plsbe_pkg::FB_W'(plsbe_pkg::MAX_BYTES);
    else
      frame_len = cfg_frame;
    if (latch_phase) begin
      if (latch_done >= cfg_latch) begin
        latch_done  = '0;
        latch_phase = 1'b0;
        bit_now     = '0;
        byte_now    = '0;
      end else begin
        latch_done = latch_done + 1'b1;
      end
    end else if (bit_now != 3'd7) begin
      bit_now = bit_now + 1'b1;
    end else begin
      bit_now = '0;
      if (byte_now + 1'b1 >= frame_len) begin
        byte_now    = '0;
        latch_phase = 1'b1;
        latch_done  = '0;
      end else begin
        byte_now = byte_now + 1'b1;
      end
    end
  endfunction

  // Apply one beat to the model and return the pin view it produces
  function automatic pin_view_t encode_item(logic cmd,
                                            logic [plsbe_pkg::SEL_W-1:0] sel,
                                            logic [plsbe_pkg::ADDR_W-1:0] addr,
                                            logic [plsbe_pkg::BYTE_W-1:0] val);
    pin_view_t view;
    logic [plsbe_pkg::TICK_W:0] next_tick;
    if (cmd == plsbe_pkg::CMD_WRITE && sel < plsbe_pkg::STRIPS)
      frame_copy[addr][sel] = val;
    view.pins  = live_pins();
    view.latch = latch_phase;
    if (cmd == plsbe_pkg::CMD_TICK) begin
      next_tick = {1'b0, tick_now} + 1'b1;
      if (next_tick >= {1'b0, cfg_period}) begin
        tick_now = '0;
        close_period();
      end else begin
        tick_now = next_tick[plsbe_pkg::TICK_W-1:0];
      end
    end
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes, prediction, checking and the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    pin_view_t want;
    logic      item_beat;
    logic      result_beat;
    item_beat   = !rst && item_ch.valid && item_ch.ready;
    result_beat = !rst && result_ch.valid && result_ch.ready;
    item_taken   <= item_beat;
    result_taken <= result_beat;

    if (item_beat)
      levels_due.push_back(encode_item(item_ch.cmd, item_ch.strip_sel,
                                       item_ch.byte_addr, item_ch.byte_value));

    if (result_beat) begin
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing outstanding (pins %b latch %b)",
                   $time, result_ch.pin_levels, result_ch.in_latch);
      end else begin
        want = levels_due.pop_front();
        if (result_ch.pin_levels !== want.pins || result_ch.in_latch !== want.latch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pins exp %b got %b, latch exp %b got %b", $time,
                     want.pins, result_ch.pin_levels, want.latch, result_ch.in_latch);
        end
      end
    end

    // hang detection
    if (rst || item_beat || result_beat) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Item driver: random gap after each beat, optional drain before a beat
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    int         gap;
    strip_cmd_t nxt;
    if (!rst && (item_taken || !item_ch.valid)) begin
      gap = item_taken ? (send_quiet ? 0 : int'($urandom_range(0, 19))) : send_gap;
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        send_gap      <= gap - 1;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].hold && levels_due.size() != 0)) begin
        nxt = cmd_backlog.pop_front();
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= nxt.cmd;
        item_ch.strip_sel  <= nxt.sel;
        item_ch.byte_addr  <= nxt.addr;
        item_ch.byte_value <= nxt.val;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall before taking each beat
  always @(negedge clk) begin : drive_ready
    int stall;
    if (!rst && (result_taken || !result_ch.ready)) begin
      stall = result_taken ? (take_quiet ? 0 : int'($urandom_range(0, 19))) : take_gap;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        take_gap        <= stall - 1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(bit hold, logic cmd, int sel, int addr, int val);
    strip_cmd_t c;
    c.hold = hold;
    c.cmd  = cmd;
    c.sel  = plsbe_pkg::SEL_W'(sel);
    c.addr = plsbe_pkg::ADDR_W'(addr);
    c.val  = plsbe_pkg::BYTE_W'(val);
    cmd_backlog.push_back(c);
  endtask

  // APB write: setup then access; the model follows once the write lands
  task automatic apb_write(logic [2:0] idx, logic [plsbe_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= plsbe_pkg::PADDR_W'(4 * idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      plsbe_pkg::REG_PERIOD:    cfg_period = data[plsbe_pkg::TICK_W-1:0];
      plsbe_pkg::REG_HIGH_ZERO: cfg_high0  = data[plsbe_pkg::TICK_W-1:0];
      plsbe_pkg::REG_HIGH_ONE:  cfg_high1  = data[plsbe_pkg::TICK_W-1:0];
      plsbe_pkg::REG_RESET_PER: cfg_latch  = data[plsbe_pkg::RP_W-1:0];
      plsbe_pkg::REG_FRAME_LEN: cfg_frame  = data[plsbe_pkg::FB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(int unsigned period, int unsigned high0, int unsigned high1,
                            int unsigned latch, int unsigned frame);
    apb_write(plsbe_pkg::REG_PERIOD, plsbe_pkg::PDATA_W'(period));
    apb_write(plsbe_pkg::REG_HIGH_ZERO, plsbe_pkg::PDATA_W'(high0));
    apb_write(plsbe_pkg::REG_HIGH_ONE, plsbe_pkg::PDATA_W'(high1));
    apb_write(plsbe_pkg::REG_RESET_PER, plsbe_pkg::PDATA_W'(latch));
    apb_write(plsbe_pkg::REG_FRAME_LEN, plsbe_pkg::PDATA_W'(frame));
  endtask

  // Wait until every queued beat is sent and every result is back
  task automatic settle();
    while (cmd_backlog.size() != 0 || item_ch.valid || levels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned draw_high_time(int unsigned period);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, period + 1);
    endcase
  endfunction

  // Mostly ticks; writes mostly land on the first bytes of the frame so they
  // show up on the pins, the rest go anywhere including absent strips
  task automatic queue_random_items(int count, bit with_hold);
    int roll;
    int span;
    bit hold_now;
    @(posedge clk);
    span = (cfg_frame == '0) ? 1 : ((cfg_frame > 8) ? 8 : int'(cfg_frame));
    for (int i = 0; i < count; i++) begin
      roll     = $urandom_range(0, 9);
      hold_now = with_hold && i == count / 2;
      if (roll < 7)
        push_cmd(hold_now, plsbe_pkg::CMD_TICK, $urandom_range(0, 7),
                 $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (roll < 9)
        push_cmd(hold_now, plsbe_pkg::CMD_WRITE, $urandom_range(0, plsbe_pkg::STRIPS - 1),
                 $urandom_range(0, span - 1), $urandom_range(0, 255));
      else
        push_cmd(hold_now, plsbe_pkg::CMD_WRITE, $urandom_range(0, 7),
                 $urandom_range(0, 1023), $urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned period;
    int unsigned frame;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = plsbe_pkg::CMD_TICK;
    item_ch.strip_sel  = '0;
    item_ch.byte_addr  = '0;
    item_ch.byte_value = '0;
    result_ch.ready    = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default timing: still in the latch, pins low; absent strips ignored
    push_cmd(1'b0, plsbe_pkg::CMD_TICK, 0, 0, 0);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 0, 0, 8'hff);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 7, 1023, 8'hff);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 4, 1023, 8'h00);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 5, 0, 8'h5a);
    settle();

    // Two-tick periods, zero bits never high, one bits high all period,
    // one-byte frame and a one-period latch
    set_timing(2, 0, 2, 0, 1);
    apb_write(REG_SPARE, 32'hffff_ffff);
    @(posedge clk);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 1, 0, 8'h80);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 2, 0, 8'h01);
    push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 3, 0, 8'ha5);
    for (int i = 0; i < 18; i++) begin
      // overwrite the byte being sent mid-way through it
      if (i == 9)
        push_cmd(1'b0, plsbe_pkg::CMD_WRITE, 4, 0, 8'hff);
      push_cmd(1'b0, plsbe_pkg::CMD_TICK, 0, 0, 0);
    end
    settle();

    // Random phases, the first few pinned to the register extremes
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: set_timing(65535, 65535, 65535, 255, 1024);
        1: set_timing(0, 0, 1, 0, 0);
        2: set_timing(1, 1, 0, 1, 2047);
        3: begin
          set_timing(3, 1, 3, 0, 2);
          apb_write(REG_SPARE, 32'h0000_0001);
        end
        default: begin
          period = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
          frame  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(1, 4);
          set_timing(period, draw_high_time(period), draw_high_time(period),
                     $urandom_range(0, 3), frame);
        end
      endcase
      send_quiet = ($urandom_range(0, 3) == 0);
      take_quiet = ($urandom_range(0, 3) == 0);
      queue_random_items(90, ph % 5 == 4);
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/plsbe_pkg.sv
hw/rtl/plsbe_if.sv
hw/rtl/plsbe_cfg.sv
hw/rtl/plsbe_front.sv
hw/rtl/plsbe_queue.sv
hw/rtl/plsbe_back.sv
hw/rtl/parallel_led_strip_bit_encoder.sv
tb/sv/tb.sv
